@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the converter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ src/pcc_pkg.sv @@
// Shared constants, types and the arctangent table of the polar/cartesian converter.
// No dependencies; compile first.
`default_nettype none

package pcc_pkg;

   // Converter size
   localparam int ITERATIONS  = 16;
   localparam int COORD_WIDTH = 16;
   localparam int TABLE_LEN   = 24;
   localparam int CELL_COUNT  = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
   localparam int TAB_IDX_W   = $clog2(TABLE_LEN);
   localparam int OUT_BITS    = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;

   // Field widths
   localparam int CMD_W = 1;
   localparam int A_W   = 17;
   localparam int B_W   = 16;
   localparam int RES_W = 17;

   // Internal formats: coordinates carry GUARD extra fraction bits, angle is 2^32 per turn
   localparam int GUARD     = 14;
   localparam int DW        = 34;
   localparam int ZW        = 34;
   localparam int ANG_SHIFT = 16;
   localparam int GAIN_W    = 30;
   localparam int GAIN_FRAC = 30;
   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

   localparam logic signed [ZW-1:0] HALF_TURN        = ZW'(64'sd2147483648);
   localparam logic signed [ZW-1:0] QUARTER_TURN     = ZW'(64'sd1073741824);
   localparam logic signed [ZW-1:0] NEG_QUARTER_TURN = ZW'(-64'sd1073741824);

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TO_RECT  = 1'b0,
      CMD_TO_POLAR = 1'b1
   } command_type;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [GAIN_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81
   };

   // Data handed from cell to cell
   typedef struct packed {
      logic                 to_polar;
      logic                 origin;
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_data_type;

endpackage

`default_nettype wire

@@ src/pcc_if.sv @@
// Request and response channel interfaces of the polar/cartesian converter.
// Depends on pcc_pkg for field widths.
`default_nettype none

interface pcc_req_if;
   import pcc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      command;
   logic signed [A_W-1:0] operand_a;
   logic signed [B_W-1:0] operand_b;

   modport source (output valid, command, operand_a, operand_b, input ready);
   modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

interface pcc_rsp_if;
   import pcc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [RES_W-1:0] result_a;
   logic signed [RES_W-1:0] result_b;

   modport source (output valid, result_a, result_b, input ready);
   modport sink (input valid, result_a, result_b, output ready);
endinterface

`default_nettype wire

@@ src/pcc_pre.sv @@
// Entry stage: gain prescale and quadrant fold ahead of the CORDIC cell chain.
// Depends on pcc_pkg and pcc_req_if.
`default_nettype none

module pcc_pre (
   input  wire                       clock,
   input  wire                       reset,
   pcc_req_if.sink                   req,
   input  wire                       en_down,
   output logic                      valid_out,
   output pcc_pkg::cordic_data_type  data_out
);
   import pcc_pkg::*;

   localparam logic signed [GAIN_W:0] GAIN_SIGNED = {1'b0, GAIN_Q30};

   logic                          en;
   logic                          valid_ff, valid_in;
   cordic_data_type               data_ff, data_in, fresh;
   logic signed [A_W+GAIN_W:0]    prod;
   logic signed [DW-1:0]          scaled, a_wide, b_wide;
   logic signed [ZW-1:0]          angle;

   // Load a new request whenever this slot is free or moves on
   assign en        = !valid_ff || en_down;
   assign req.ready = en;

   // Build the starting vector
   always_comb begin
      prod   = req.operand_a * GAIN_SIGNED;
      scaled = DW'(prod >>> (GAIN_FRAC - GUARD));
      a_wide = DW'(req.operand_a) <<< GUARD;
      b_wide = DW'(req.operand_b) <<< GUARD;
      angle  = ZW'($signed({req.operand_b, {ANG_SHIFT{1'b0}}}));

      fresh.to_polar = (req.command == CMD_TO_POLAR);
      fresh.origin   = (req.operand_a == '0) && (req.operand_b == '0);

      if (req.command == CMD_TO_POLAR) begin
         // Fold the left half-plane onto the right one
         if (a_wide < 0) begin
            fresh.x = -a_wide;
            fresh.y = -b_wide;
            fresh.z = HALF_TURN;
         end else begin
            fresh.x = a_wide;
            fresh.y = b_wide;
            fresh.z = '0;
         end
      end else begin
         // Turn wide angles by a half turn so the rotation converges
         fresh.y = '0;
         if (angle > QUARTER_TURN) begin
            fresh.x = -scaled;
            fresh.z = angle - HALF_TURN;
         end else if (angle < NEG_QUARTER_TURN) begin
            fresh.x = -scaled;
            fresh.z = angle + HALF_TURN;
         end else begin
            fresh.x = scaled;
            fresh.z = angle;
         end
      end
   end

   // Advance or hold
   always_comb begin
      valid_in = en ? req.valid : valid_ff;
      data_in  = en ? fresh : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

@@ src/pcc_cell.sv @@
// One CORDIC micro-rotation cell; rotation or vectoring chosen per request.
// Depends on pcc_pkg for the data type and the arctangent table.
`default_nettype none

module pcc_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  wire [pcc_pkg::TAB_IDX_W-1:0]  stage_index,
   input  wire                           valid_up,
   input  pcc_pkg::cordic_data_type      data_up,
   output logic                          en_up,
   input  wire                           en_down,
   output logic                          valid_out,
   output pcc_pkg::cordic_data_type      data_out
);
   import pcc_pkg::*;

   logic                 valid_ff, valid_in;
   cordic_data_type      data_ff, data_in, rotated;
   logic signed [DW-1:0] xs, ys;
   logic signed [ZW-1:0] step;
   logic                 turn_neg;

   assign en_up = !valid_ff || en_down;

   // Micro-rotation: vectoring drives y to zero, rotation drives z to zero
   always_comb begin
      xs       = data_up.x >>> stage_index;
      ys       = data_up.y >>> stage_index;
      step     = $signed(ZW'(ATAN_TABLE[stage_index]));
      turn_neg = data_up.to_polar ? data_up.y[DW-1] : !data_up.z[ZW-1];
      rotated  = data_up;
      if (turn_neg) begin
         rotated.x = data_up.x - ys;
         rotated.y = data_up.y + xs;
         rotated.z = data_up.z - step;
      end else begin
         rotated.x = data_up.x + ys;
         rotated.y = data_up.y - xs;
         rotated.z = data_up.z + step;
      end
   end

   // Advance or hold
   always_comb begin
      valid_in = en_up ? valid_up : valid_ff;
      data_in  = en_up ? rotated : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

@@ src/pcc_post.sv @@
// Exit stages: rounding, magnitude gain, saturation and the response register.
// Depends on pcc_pkg and pcc_rsp_if.
`default_nettype none

module pcc_post (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       valid_up,
   input  pcc_pkg::cordic_data_type  data_up,
   output logic                      en_up,
   pcc_rsp_if.source                 rsp
);
   import pcc_pkg::*;

   localparam int MX_W   = DW - 3;
   localparam int PROD_W = MX_W + GAIN_W;
   localparam int MAG_SH = GAIN_FRAC + GUARD;
   localparam int MAG_W  = PROD_W + 1 - MAG_SH;

   localparam logic signed [DW-1:0] SAT_HI     = DW'((1 << OUT_BITS) - 1);
   localparam logic signed [DW-1:0] SAT_LO     = DW'(-(1 << OUT_BITS));
   localparam logic signed [DW-1:0] COORD_HALF = DW'(1 << (GUARD - 1));
   localparam logic signed [ZW-1:0] ANG_HALF   = ZW'(1 << (ANG_SHIFT - 1));
   localparam logic [PROD_W:0]      MAG_HALF   = (PROD_W + 1)'(1) << (MAG_SH - 1);
   localparam logic [MAG_W-1:0]     MAG_HI     = MAG_W'((1 << OUT_BITS) - 1);

   // Clamp a rounded coordinate to the output range
   function automatic logic signed [RES_W-1:0] sat_coord(input logic signed [DW-1:0] v);
      logic signed [DW-1:0] c;
      c = v;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end
      return RES_W'(c);
   endfunction

   logic                    en_a, en_b;
   logic                    valid_a_ff, valid_a_in;
   logic                    polar_a_ff, polar_a_in;
   logic                    origin_a_ff, origin_a_in;
   logic signed [RES_W-1:0] coord_a_ff, coord_a_in;
   logic signed [RES_W-1:0] side_b_ff, side_b_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    valid_b_ff, valid_b_in;
   logic signed [RES_W-1:0] res_a_ff, res_a_in;
   logic signed [RES_W-1:0] res_b_ff, res_b_in;
   logic signed [DW-1:0]    rx, ry;
   logic signed [ZW-1:0]    zr;
   logic [PROD_W:0]         mag_sum;
   logic [MAG_W-1:0]        mag;
   logic signed [RES_W-1:0] mag_sat;

   assign en_b  = !valid_b_ff || rsp.ready;
   assign en_a  = !valid_a_ff || en_b;
   assign en_up = en_a;

   // First stage: round coordinates and angle, scale magnitude by the gain
   always_comb begin
      rx = (data_up.x + COORD_HALF) >>> GUARD;
      ry = (data_up.y + COORD_HALF) >>> GUARD;
      zr = data_up.z + ANG_HALF;
      if (en_a) begin
         valid_a_in  = valid_up;
         polar_a_in  = data_up.to_polar;
         origin_a_in = data_up.origin;
         coord_a_in  = sat_coord(rx);
         side_b_in   = data_up.to_polar ? RES_W'($signed(zr[ANG_SHIFT +: B_W]))
                                        : sat_coord(ry);
         prod_in     = PROD_W'(data_up.x[MX_W-1:0]) * PROD_W'(GAIN_Q30);
      end else begin
         valid_a_in  = valid_a_ff;
         polar_a_in  = polar_a_ff;
         origin_a_in = origin_a_ff;
         coord_a_in  = coord_a_ff;
         side_b_in   = side_b_ff;
         prod_in     = prod_ff;
      end
   end

   // Second stage: round and clamp the magnitude, pick the response
   always_comb begin
      mag_sum = {1'b0, prod_ff} + MAG_HALF;
      mag     = mag_sum[MAG_SH +: MAG_W];
      mag_sat = (mag > MAG_HI) ? RES_W'(MAG_HI) : RES_W'(mag);
      if (en_b) begin
         valid_b_in = valid_a_ff;
         if (!polar_a_ff) begin
            res_a_in = coord_a_ff;
            res_b_in = side_b_ff;
         end else if (origin_a_ff) begin
            res_a_in = '0;
            res_b_in = '0;
         end else begin
            res_a_in = mag_sat;
            res_b_in = side_b_ff;
         end
      end else begin
         valid_b_in = valid_b_ff;
         res_a_in   = res_a_ff;
         res_b_in   = res_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
      polar_a_ff  <= polar_a_in;
      origin_a_ff <= origin_a_in;
      coord_a_ff  <= coord_a_in;
      side_b_ff   <= side_b_in;
      prod_ff     <= prod_in;
      res_a_ff    <= res_a_in;
      res_b_ff    <= res_b_in;
   end

   assign rsp.valid    = valid_b_ff;
   assign rsp.result_a = res_a_ff;
   assign rsp.result_b = res_b_ff;

endmodule

`default_nettype wire

@@ src/polar_cartesian_converter_core.sv @@
// Stages: entry stage, one register stage per CORDIC cell, two exit stages. Throughput: one
// request per cycle while the response side takes responses, set by the unrolled cell chain;
// any stage that is empty or moving on takes new data, so bubbles close up under back-pressure.
// Reset (synchronous, active high) clears all stage valid bits; no clearing pass is needed.
// Depends on pcc_pkg, pcc_if, pcc_pre, pcc_cell and pcc_post.
`default_nettype none

module polar_cartesian_converter_core (
   input  wire        clock,
   input  wire        reset,
   pcc_req_if.sink    req,
   pcc_rsp_if.source  rsp
);
   import pcc_pkg::*;

   cordic_data_type chain_data  [CELL_COUNT+1];
   logic            chain_valid [CELL_COUNT+1];
   logic            chain_en    [CELL_COUNT+1];

   // Prescale and fold
   pcc_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .en_down   (chain_en[0]),
      .valid_out (chain_valid[0]),
      .data_out  (chain_data[0])
   );

   // Micro-rotation chain
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      pcc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .stage_index (TAB_IDX_W'(i)),
         .valid_up    (chain_valid[i]),
         .data_up     (chain_data[i]),
         .en_up       (chain_en[i]),
         .en_down     (chain_en[i+1]),
         .valid_out   (chain_valid[i+1]),
         .data_out    (chain_data[i+1])
      );
   end

   // Round, clamp and respond
   pcc_post u_post (
      .clock    (clock),
      .reset    (reset),
      .valid_up (chain_valid[CELL_COUNT]),
      .data_up  (chain_data[CELL_COUNT]),
      .en_up    (chain_en[CELL_COUNT]),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

@@ src/pcc_checker.sv @@
// Port-level checks of the polar/cartesian converter, bound to the top level.
// Depends on assert_macros.svh and pcc_pkg.
`default_nettype none
`include "assert_macros.svh"

module pcc_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [pcc_pkg::RES_W-1:0]     rsp_result_a,
   input wire [pcc_pkg::RES_W-1:0]     rsp_result_b
);
   import pcc_pkg::*;

   // A pending response stays offered until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A pending response keeps its payload
   `ASSERT_NEXT(a_rsp_stable_a, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_result_a))
   `ASSERT_NEXT(a_rsp_stable_b, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_result_b))

   // Reset empties the pipeline
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A consumer that keeps up never stalls the request side
   `ASSERT_IMPLIES(a_flow_through, clock, reset, rsp_ready, req_ready || !req_valid && req_ready)

endmodule

bind polar_cartesian_converter_core pcc_checker u_pcc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_result_a (rsp.result_a),
   .rsp_result_b (rsp.result_b)
);

`default_nettype wire

@@ bench/pcc_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the polar/cartesian converter: predicts each conversion on request
// acceptance and compares every accepted response with the oldest prediction.
// Depends on pcc_pkg and the pcc_req_if / pcc_rsp_if channel interfaces.

module pcc_result_checker (
   input  wire clock,
   input  wire reset,
   pcc_req_if  req,
   pcc_rsp_if  rsp,
   output int  mismatch_count,
   output int  pending_count
);
   import pcc_pkg::*;

   // Micro-rotation count is capped by the arctangent table length
   localparam int     ROTATIONS = (ITERATIONS > 24) ? 24 : ITERATIONS;
   localparam int     SAT_BITS  = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
   localparam int     FRAC_EXT  = 14;
   localparam longint CORDIC_K  = 64'sd652032874;
   localparam longint PI_TURN   = 64'sd2147483648;
   localparam longint PI_HALF   = 64'sd1073741824;

   // atan(2^-i) in 2^-32 turn units
   localparam longint ARC_STEP [24] = '{
      536870912, 316933406, 167458907, 85004756,
      42667331,  21354465,  10679838,  5340245,
      2670163,   1335087,   667544,    333772,
      166886,    83443,     41722,     20861,
      10430,     5215,      2608,      1304,
      652,       326,       163,       81
   };

   typedef struct {
      command_type             cmd;
      logic signed [A_W-1:0]   operand_a;
      logic signed [B_W-1:0]   operand_b;
      logic signed [RES_W-1:0] result_a;
      logic signed [RES_W-1:0] result_b;
   } conversion_type;

   conversion_type predicted_q[$];

   function automatic longint round_half_up(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_coord(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< SAT_BITS) - 1;
      lo = -(longint'(1) <<< SAT_BITS);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Work out the converted pair for one request
   function automatic conversion_type convert(input command_type cmd,
                                              input logic signed [A_W-1:0] a,
                                              input logic signed [B_W-1:0] b);
      conversion_type   r;
      longint           x;
      longint           y;
      longint           z;
      longint           xs;
      longint           ys;
      logic signed [15:0] wrapped;
      r.cmd       = cmd;
      r.operand_a = a;
      r.operand_b = b;
      if (cmd == CMD_TO_RECT) begin
         // Rotate the pre-scaled radius toward the angle
         x = (longint'(a) * CORDIC_K) >>> (30 - FRAC_EXT);
         y = 0;
         z = longint'(b) * 65536;
         // Fold wide angles by half a turn
         if (z > PI_HALF) begin
            z = z - PI_TURN;
            x = -x;
         end else if (z < -PI_HALF) begin
            z = z + PI_TURN;
            x = -x;
         end
         for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - ARC_STEP[i];
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + ARC_STEP[i];
            end
         end
         r.result_a = RES_W'(clamp_coord(round_half_up(x, FRAC_EXT)));
         r.result_b = RES_W'(clamp_coord(round_half_up(y, FRAC_EXT)));
      end else if (a == 0 && b == 0) begin
         r.result_a = '0;
         r.result_b = '0;
      end else begin
         // Vector mode: drive y to zero, accumulate the angle
         x = longint'(a) * 16384;
         y = longint'(b) * 16384;
         z = 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = PI_TURN;
         end
         for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
               x = x - ys;
               y = y + xs;
               z = z - ARC_STEP[i];
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + ARC_STEP[i];
            end
         end
         wrapped    = 16'(round_half_up(z, 16));
         r.result_a = RES_W'(clamp_coord(round_half_up(x * CORDIC_K, 30 + FRAC_EXT)));
         r.result_b = RES_W'(wrapped);
      end
      return r;
   endfunction

   // Compare responses first, then record new requests
   always @(posedge clock) begin
      conversion_type want;
      if (reset) begin
         predicted_q.delete();
         pending_count  <= 0;
         mismatch_count <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (predicted_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected response a=%0d b=%0d", $realtime,
                           rsp.result_a, rsp.result_b);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = predicted_q.pop_front();
               if (rsp.result_a !== want.result_a || rsp.result_b !== want.result_b) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: mismatch cmd=%s in=(%0d,%0d)",
                              $realtime, want.cmd.name(), want.operand_a, want.operand_b);
                     $display("   expected=(%0d,%0d) actual=(%0d,%0d)",
                              want.result_a, want.result_b, rsp.result_a, rsp.result_b);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req.valid && req.ready)
            predicted_q.push_back(convert(command_type'(req.command), req.operand_a,
                                          req.operand_b));
         pending_count <= predicted_q.size();
      end
   end

endmodule

@@ bench/tb_polar_cartesian_converter_core.sv @@
`timescale 1ns / 100ps
// Testbench top for polar_cartesian_converter_core: drives directed and random requests
// with random idling on both channels, and gives the verdict from pcc_result_checker.
// Depends on pcc_pkg, pcc_if, the converter RTL and pcc_result_checker.

module tb_polar_cartesian_converter_core;
   import pcc_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int SETTLE_TURNS = 40;
   localparam int CYCLE_LIMIT  = 100000;

   logic clock = 1'b0;
   logic reset;
   bit   steady = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count;
   int   pending_count;

   pcc_req_if req_ch ();
   pcc_rsp_if rsp_ch ();

   polar_cartesian_converter_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   pcc_result_checker conversion_monitor (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && (steady || $urandom_range(0, 99) >= 7);
   end

   // Present one request and hold it until accepted
   task automatic send_request(input command_type cmd,
                               input logic signed [A_W-1:0] a,
                               input logic signed [B_W-1:0] b);
      while (!steady && $urandom_range(0, 99) < 7) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid and hold until every predicted response has arrived
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_TO_RECT;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      rsp_ch.ready     = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Polar to rectangular: radius extremes, quadrant edges, wide angles
      send_request(CMD_TO_RECT, 17'sd0, 16'sd1000);
      send_request(CMD_TO_RECT, 17'sd65535, 16'sd0);
      send_request(CMD_TO_RECT, 17'sd65535, 16'sd16384);
      send_request(CMD_TO_RECT, 17'sd65535, 16'sd16385);
      send_request(CMD_TO_RECT, 17'sd65535, -16'sd16384);
      send_request(CMD_TO_RECT, 17'sd65535, -16'sd16385);
      send_request(CMD_TO_RECT, 17'sd65535, -16'sd32768);
      send_request(CMD_TO_RECT, 17'sd65535, 16'sd32767);
      send_request(CMD_TO_RECT, -17'sd32768, 16'sd8192);
      send_request(CMD_TO_RECT, -17'sd65536, -16'sd24000);
      send_request(CMD_TO_RECT, 17'sd256, 16'sd8192);
      send_request(CMD_TO_RECT, 17'sd1, -16'sd1);
      // Rectangular to polar: origin, axes, left half-plane, saturation
      send_request(CMD_TO_POLAR, 17'sd0, 16'sd0);
      send_request(CMD_TO_POLAR, 17'sd0, 16'sd32767);
      send_request(CMD_TO_POLAR, 17'sd0, -16'sd32768);
      send_request(CMD_TO_POLAR, -17'sd1, 16'sd0);
      send_request(CMD_TO_POLAR, -17'sd65536, 16'sd0);
      send_request(CMD_TO_POLAR, -17'sd65536, -16'sd32768);
      send_request(CMD_TO_POLAR, -17'sd65536, 16'sd32767);
      send_request(CMD_TO_POLAR, 17'sd65535, 16'sd32767);
      send_request(CMD_TO_POLAR, 17'sd65535, -16'sd1);
      send_request(CMD_TO_POLAR, 17'sd100, -16'sd5);
      send_request(CMD_TO_POLAR, -17'sd300, 16'sd1);

      // Random requests; a quiet stretch with no idling in the middle
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         command_type           cmd;
         logic signed [A_W-1:0] a;
         logic signed [B_W-1:0] b;
         int                    pick;
         steady = (n >= 250 && n < 400);
         if (n == 150)
            wait_for_drain();
         cmd  = command_type'($urandom_range(0, 1));
         pick = $urandom_range(0, 9);
         if (pick < 2)
            a = A_W'(int'($urandom_range(0, 600)) - 300);
         else if (cmd == CMD_TO_RECT && pick < 8)
            a = A_W'($urandom_range(0, 65535));
         else
            a = A_W'($urandom());
         if ($urandom_range(0, 4) == 0)
            b = B_W'(int'($urandom_range(0, 600)) - 300);
         else
            b = B_W'($urandom());
         // Land on an axis now and then
         if ($urandom_range(0, 19) == 0)
            a = '0;
         if ($urandom_range(0, 19) == 0)
            b = '0;
         send_request(cmd, a, b);
      end
      steady = 1'b0;

      // Drain and settle, then report
      wait_for_drain();
      repeat (SETTLE_TURNS) @(negedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
